// File: rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Holds the character codes, phase and error codes, and the classified beat type.
// Depends on nothing; every other file imports it.
`default_nettype none

package jsu_pkg;

	// Character codes seen in escaped string bodies.
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_U   = 8'h75;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// Escape phase codes.
	localparam logic [2:0] PH_NORMAL = 3'd0;
	localparam logic [2:0] PH_ESCAPE = 3'd1;
	localparam logic [2:0] PH_HEX1   = 3'd2;
	localparam logic [2:0] PH_HEX2   = 3'd3;
	localparam logic [2:0] PH_HEX3   = 3'd4;
	localparam logic [2:0] PH_HEX4   = 3'd5;

	// Sticky error codes, reported as status.
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_TRUNC  = 2'd1;
	localparam logic [1:0] ERR_BADESC = 2'd2;

	// Unicode escape limits.
	localparam logic [15:0] HEX_LIMIT = 16'h0020;
	localparam logic [15:0] HEX_BAD   = 16'hFFFF;

	// Queue between the classifier and the decoder.
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	// One input beat after classification.
	typedef struct packed {
		logic [7:0] data;      // raw byte
		logic       last;      // final byte of the string
		logic       bslash;    // byte is a backslash
		logic       esc_hit;   // byte names a one-byte escape
		logic [7:0] esc_byte;  // byte that escape stands for
		logic       esc_u;     // byte opens a unicode escape
		logic       hex_ok;    // byte is a hex digit
		logic [3:0] hex_digit; // value of that digit
	} jsu_item_t;

endpackage

`default_nettype wire

// File: rtl/jsu_front.sv
// Front end of the unescaper: classifies each accepted byte for the decoder.
// Depends on jsu_pkg.
`default_nettype none

module jsu_front
	import jsu_pkg::*;
(
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output jsu_item_t       item
);

	// Decode escape letters and hex digits in parallel.
	always_comb begin
		item           = '0;
		item.data      = in_byte;
		item.last      = in_last;
		item.bslash    = (in_byte == CH_BSLASH);
		item.esc_u     = (in_byte == CH_LC_U);
		item.esc_hit   = 1'b1;
		item.esc_byte  = in_byte;
		case (in_byte)
			CH_QUOTE, CH_BSLASH, CH_SLASH: item.esc_byte = in_byte;
			CH_LC_B: item.esc_byte = CH_BS;
			CH_LC_T: item.esc_byte = CH_TAB;
			CH_LC_N: item.esc_byte = CH_LF;
			CH_LC_F: item.esc_byte = CH_FF;
			CH_LC_R: item.esc_byte = CH_CR;
			default: item.esc_hit  = 1'b0;
		endcase

		item.hex_ok    = 1'b1;
		item.hex_digit = 4'd0;
		if (in_byte inside {[8'h30:8'h39]}) begin
			item.hex_digit = 4'(in_byte - 8'h30);
		end else if (in_byte inside {[8'h61:8'h66]}) begin
			item.hex_digit = 4'(in_byte - 8'h57);
		end else if (in_byte inside {[8'h41:8'h46]}) begin
			item.hex_digit = 4'(in_byte - 8'h37);
		end else begin
			item.hex_ok    = 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: rtl/jsu_fifo.sv
// Short queue of classified beats between the front end and the decoder.
// Depends on jsu_pkg for the item type and depth.
`default_nettype none

module jsu_fifo
	import jsu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire jsu_item_t push_item,
	output logic           full,
	input  wire logic      pop,
	output jsu_item_t      pop_item,
	output logic           empty
);

	jsu_item_t             mem [FIFO_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;

	assign full     = (count_q == CNT_W'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem[rd_ptr_q];

	// Storage is written only on a push.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/jsu_back.sv
// Back end of the unescaper: runs the escape state machine and drives the result register.
// Depends on jsu_pkg.
`default_nettype none

module jsu_back
	import jsu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_avail,
	input  wire jsu_item_t  item,
	output logic            item_pop,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,  // out_byte
	output logic [2:0]      m_tuser,  // [0] out_valid, [2:1] status
	output logic            m_tlast   // string_done
);

	logic [2:0]  phase_q;
	logic [15:0] hex_q;
	logic [1:0]  err_q;
	logic        m_valid_q;
	logic [7:0]  obyte_q;
	logic        ovalid_q;
	logic [1:0]  status_q;
	logic        done_q;

	logic [2:0]  ph_n;
	logic [15:0] acc_n;
	logic [1:0]  err_n;
	logic        val_n;
	logic [7:0]  ob_n;

	// The result register frees up when empty or when its beat is taken.
	assign item_pop = item_avail && (!m_valid_q || m_tready);

	// Next state and result for the beat at the head of the queue.
	always_comb begin
		ph_n  = phase_q;
		acc_n = hex_q;
		err_n = err_q;
		val_n = 1'b0;
		ob_n  = 8'd0;
		case (phase_q)
			PH_NORMAL: begin
				if (item.bslash) begin
					ph_n = PH_ESCAPE;
				end else begin
					ob_n  = item.data;
					val_n = 1'b1;
				end
			end
			PH_ESCAPE: begin
				ph_n = PH_NORMAL;
				if (item.esc_hit) begin
					ob_n  = item.esc_byte;
					val_n = 1'b1;
				end else if (item.esc_u) begin
					ph_n  = PH_HEX1;
					acc_n = 16'd0;
				end
			end
			PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
				if (!item.hex_ok || hex_q == HEX_BAD) begin
					acc_n = HEX_BAD;
				end else begin
					acc_n = {hex_q[11:0], item.hex_digit};
				end
				if (phase_q == PH_HEX4) begin
					ph_n = PH_NORMAL;
					if (acc_n > HEX_LIMIT) begin
						if (err_q == ERR_NONE) begin
							err_n = ERR_BADESC;
						end
					end else begin
						ob_n  = acc_n[7:0];
						val_n = 1'b1;
					end
					acc_n = 16'd0;
				end else begin
					ph_n = 3'(phase_q + 1'b1);
				end
			end
			default: ph_n = PH_NORMAL;
		endcase

		// An escape left open at the end of the string is a truncation.
		if (item.last && ph_n != PH_NORMAL && err_n == ERR_NONE) begin
			err_n = ERR_TRUNC;
		end

		// A pending error mutes the output.
		if (err_n != ERR_NONE) begin
			val_n = 1'b0;
			ob_n  = 8'd0;
		end
	end

	// Decoder state; the end of a string returns it to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			hex_q   <= 16'd0;
			err_q   <= ERR_NONE;
		end else if (item_pop) begin
			if (item.last) begin
				phase_q <= PH_NORMAL;
				hex_q   <= 16'd0;
				err_q   <= ERR_NONE;
			end else begin
				phase_q <= ph_n;
				hex_q   <= acc_n;
				err_q   <= err_n;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (item_pop) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (item_pop) begin
			obyte_q  <= ob_n;
			ovalid_q <= val_n;
			status_q <= err_n;
			done_q   <= item.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = obyte_q;
	assign m_tuser  = {status_q, ovalid_q};
	assign m_tlast  = done_q;

endmodule

`default_nettype wire

// File: rtl/json_string_unescaper.sv
// JSON string body unescaper: one byte in, one result beat out.
// An accepted byte is written into the queue, then popped by the decoder into the result register on the master side.
// Throughput: one byte per cycle while the queue has room and the master side does not stall.
// A four-beat queue lets the input side run ahead while the output stalls.
// Reset (arst_n low) empties the queue and returns the decoder to normal, no error.
`default_nettype none

module json_string_unescaper
	import jsu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // in_byte
	input  wire logic       s_tlast,  // is_last
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,  // out_byte
	output logic [2:0]      m_tuser,  // [0] out_valid, [2:1] status
	output logic            m_tlast   // string_done
);

	jsu_item_t cls_item;
	jsu_item_t head_item;
	logic      fifo_full;
	logic      fifo_empty;
	logic      fifo_pop;
	logic      fifo_push;

	assign s_tready  = !fifo_full;
	assign fifo_push = s_tvalid && !fifo_full;

	// Classify incoming bytes.
	jsu_front u_front (
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.item    (cls_item)
	);

	// Queue between classifier and decoder.
	jsu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_item (cls_item),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.pop_item  (head_item),
		.empty     (fifo_empty)
	);

	// Escape decoder and result register.
	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_avail (!fifo_empty),
		.item       (head_item),
		.item_pop   (fifo_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	// A decoded byte never goes out alongside an error.
	a_valid_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ERR_NONE)
		else $error("decoded byte delivered with an error status");

	// Status is one of the three defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[2:1] == ERR_NONE || m_tuser[2:1] == ERR_TRUNC ||
			m_tuser[2:1] == ERR_BADESC))
		else $error("undefined status code");

	// Beats without a decoded byte carry a zero byte.
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
		else $error("non-zero byte on a beat without output");

	// Truncation is only reported on the final beat of a string.
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:1] == ERR_TRUNC |-> m_tlast)
		else $error("truncation status before end of string");

endmodule

`default_nettype wire
